// File: design/rgb555_luma_gradient_bump_map_macros.svh
// ----------------------------------------------------------------------------
// rgb555 luma gradient bump map: assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RGB555_LUMA_GRADIENT_BUMP_MAP_MACROS_SVH
`define RGB555_LUMA_GRADIENT_BUMP_MAP_MACROS_SVH

`ifndef SYNTHESIS

`define RLGBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define RLGBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RLGBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLGBM_ASSERT(lbl, prop, msg)
`define RLGBM_ASSERT_IMPL(lbl, ante, cons, msg)
`define RLGBM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/rlgbm_pkg.sv
// ----------------------------------------------------------------------------
// rlgbm_pkg
// Widths, register indexes and gray conversion constants of the bump mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rlgbm_pkg;

  localparam int unsigned DefaultMaxWidth = 256;

  localparam int PixW    = 16;
  localparam int CoordW  = 8;
  localparam int GrayW   = 8;
  localparam int CfgW    = 9;
  localparam int CfgIdxW = 1;
  localparam int SumW    = 15;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  localparam logic [CfgW-1:0] CfgReset = 9'd128;

  // luma weights in hundredths
  localparam logic [SumW-1:0] CoefR = 15'd29;
  localparam logic [SumW-1:0] CoefG = 15'd60;
  localparam logic [SumW-1:0] CoefB = 15'd11;

  // floor(x / 100) for x below 2^15 as (x * 5243) >> 19
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int ProdW      = SumW + RecipW;
  localparam logic [RecipW-1:0] RecipMul = 13'd5243;

endpackage

`default_nettype wire

// File: design/rlgbm_line_buf.sv
// ----------------------------------------------------------------------------
// rlgbm_line_buf
// Gray line buffer: two registered read ports and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlgbm_line_buf #(
  parameter int unsigned Depth = rlgbm_pkg::DefaultMaxWidth
) (
  input  logic                                           clk_i,
  input  logic                                           rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   rd_addr_c_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   rd_addr_r_i,
  output logic [rlgbm_pkg::GrayW-1:0]                    rd_c_o,
  output logic [rlgbm_pkg::GrayW-1:0]                    rd_r_o,
  input  logic                                           wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   wr_addr_i,
  input  logic [rlgbm_pkg::GrayW-1:0]                    wr_data_i
);
  import rlgbm_pkg::*;

  logic [GrayW-1:0] mem [Depth];
  logic [GrayW-1:0] rd_c_q;
  logic [GrayW-1:0] rd_r_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_c_q <= mem[rd_addr_c_i];
      rd_r_q <= mem[rd_addr_r_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_c_o = rd_c_q;
  assign rd_r_o = rd_r_q;

endmodule

`default_nettype wire

// File: design/rgb555_luma_gradient_bump_map.sv
// ----------------------------------------------------------------------------
// rgb555_luma_gradient_bump_map
// Gray conversion of raster RGB555 pixels and forward differences to the
// right and lower neighbours, with the previous row held in a line buffer.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   pixel_color_i
//   out      out        out_valid_o / out_stall_i row, col, du, dv, last flags
//
// One pixel per cycle while each pixel yields at most one word and out_stall_i
// is low; a last-row pixel with a row above and a left neighbour yields two
// words (three at the final pixel) and holds the input until the single output
// register stage has sent its last word.
// A pixel accepted at one edge shows its first word after the next edge when
// the output stage is free (line buffer read, then gray and differences).
// Reset returns to row 0, column 0 with both sizes 128; the line buffer is
// not cleared. out_stall_i holds the output stage and backs up to in_stall_o
// through one pixel stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb555_luma_gradient_bump_map_macros.svh"

module rgb555_luma_gradient_bump_map #(
  parameter int unsigned MaxWidth = rlgbm_pkg::DefaultMaxWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rlgbm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rlgbm_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rlgbm_pkg::PixW-1:0]        pixel_color_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rlgbm_pkg::CoordW-1:0]      out_row_o,
  output logic [rlgbm_pkg::CoordW-1:0]      out_col_o,
  output logic signed [rlgbm_pkg::GrayW-1:0] delta_u_o,
  output logic signed [rlgbm_pkg::GrayW-1:0] delta_v_o,
  output logic                              last_of_run_o,
  output logic                              last_of_image_o
);
  import rlgbm_pkg::*;

  localparam int AddrW    = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int WidthLim = (MaxWidth < 256) ? MaxWidth : 256;
  localparam int HeightLim = 256;

  // configuration and position
  logic [CfgW-1:0]   width_q, height_q;
  logic [CfgW-1:0]   w_eff, h_eff;
  logic [CoordW-1:0] row_q, col_q, row_d, col_d;
  logic              col_last, row_last;

  // pixel stage
  logic              a_valid_q;
  logic [SumW-1:0]   a_sum_q;
  logic [CoordW-1:0] a_row_q, a_col_q;
  logic              a_up_q, a_lrow_q, a_fcol_q, a_lcol_q;
  logic              a_fwd_c_q, a_fwd_r_q;
  logic [GrayW-1:0]  prev_gray_q;

  // result stage
  logic [2:0]        b_mask_q, b_mask_d;
  logic [CoordW-1:0] b_row_q, b_col_q, b_row_up_q, b_col_left_q;
  logic [GrayW-1:0]  b_du0_q, b_dv0_q, b_du1_q;

  logic              in_fire, a_fire, out_fire, b_free;
  logic [SumW-1:0]   sum_d;
  logic [SumW-1:0]   red, green, blue;
  logic [ProdW-1:0]  prod;
  logic [GrayW-1:0]  a_gray, mem_c, mem_r, center, right;
  logic [AddrW-1:0]  rd_addr_c, rd_addr_r, wr_addr;
  logic [2:0]        sel, rest;

  // effective sizes
  always_comb begin
    if (width_q == '0) begin
      w_eff = 9'd1;
    end else if (width_q > CfgW'(WidthLim)) begin
      w_eff = CfgW'(WidthLim);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = 9'd1;
    end else if (height_q > CfgW'(HeightLim)) begin
      h_eff = CfgW'(HeightLim);
    end else begin
      h_eff = height_q;
    end
  end

  assign col_last = (CfgW'(col_q) == (w_eff - 9'd1));
  assign row_last = (CfgW'(row_q) == (h_eff - 9'd1));

  always_comb begin
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + 8'd1;
    end else begin
      col_d = col_q + 8'd1;
      row_d = row_q;
    end
  end

  // handshake
  assign b_free     = (b_mask_q == '0) || (out_fire && (rest == '0));
  assign a_fire     = a_valid_q && b_free;
  assign in_stall_o = a_valid_q && !b_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = (b_mask_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;

  // weighted channel sum
  assign red   = SumW'({pixel_color_i[14:10], 3'b000});
  assign green = SumW'({pixel_color_i[9:5], 3'b000});
  assign blue  = SumW'({pixel_color_i[4:0], 3'b000});
  assign sum_d = red * CoefR + green * CoefG + blue * CoefB;

  // divide by 100
  assign prod   = ProdW'(a_sum_q) * ProdW'(RecipMul);
  assign a_gray = prod[RecipShift +: GrayW];

  // line buffer with same-edge forwarding
  assign rd_addr_c = AddrW'(col_q);
  assign rd_addr_r = AddrW'(CfgW'(col_q) + 9'd1);
  assign wr_addr   = AddrW'(a_col_q);

  rlgbm_line_buf #(
    .Depth (MaxWidth)
  ) u_line_buf (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_c_i (rd_addr_c),
    .rd_addr_r_i (rd_addr_r),
    .rd_c_o      (mem_c),
    .rd_r_o      (mem_r),
    .wr_en_i     (a_fire),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (a_gray)
  );

  assign center = a_fwd_c_q ? prev_gray_q : mem_c;
  assign right  = a_lcol_q ? center : (a_fwd_r_q ? prev_gray_q : mem_r);

  // output word select: upper row first
  always_comb begin
    sel = 3'b000;
    if (b_mask_q[0]) begin
      sel = 3'b001;
    end else if (b_mask_q[1]) begin
      sel = 3'b010;
    end else if (b_mask_q[2]) begin
      sel = 3'b100;
    end
  end

  assign rest = b_mask_q & ~sel;

  assign out_row_o       = sel[0] ? b_row_up_q : b_row_q;
  assign out_col_o       = sel[1] ? b_col_left_q : b_col_q;
  assign delta_u_o       = sel[0] ? b_du0_q : (sel[1] ? b_du1_q : '0);
  assign delta_v_o       = sel[0] ? b_dv0_q : '0;
  assign last_of_run_o   = (rest == '0);
  assign last_of_image_o = sel[2];

  always_comb begin
    b_mask_d = b_mask_q;
    if (a_fire) begin
      b_mask_d = {a_lrow_q && a_lcol_q, a_lrow_q && !a_fcol_q, a_up_q};
    end else if (out_fire) begin
      b_mask_d = rest;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CfgReset;
      height_q    <= CfgReset;
      row_q       <= '0;
      col_q       <= '0;
      a_valid_q   <= 1'b0;
      prev_gray_q <= '0;
      b_mask_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgImageWidth: begin
            width_q <= cfg_data_i;
            row_q   <= '0;
            col_q   <= '0;
          end
          CfgImageHeight: begin
            height_q <= cfg_data_i;
            row_q    <= '0;
            col_q    <= '0;
          end
          default: begin
          end
        endcase
      end else if (in_fire) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        prev_gray_q <= a_gray;
      end
      b_mask_q <= b_mask_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_sum_q   <= sum_d;
      a_row_q   <= row_q;
      a_col_q   <= col_q;
      a_up_q    <= (row_q != '0);
      a_lrow_q  <= row_last;
      a_fcol_q  <= (col_q == '0);
      a_lcol_q  <= col_last;
      a_fwd_c_q <= a_fire && (wr_addr == rd_addr_c);
      a_fwd_r_q <= a_fire && (wr_addr == rd_addr_r);
    end
    if (a_fire) begin
      b_row_q      <= a_row_q;
      b_col_q      <= a_col_q;
      b_row_up_q   <= a_row_q - 8'd1;
      b_col_left_q <= a_col_q - 8'd1;
      b_du0_q      <= center - right;
      b_dv0_q      <= center - a_gray;
      b_du1_q      <= prev_gray_q - a_gray;
    end
  end

  `RLGBM_ASSERT(col_in_range_a, CfgW'(col_q) < w_eff, "column position beyond image width")
  `RLGBM_ASSERT_IMPL(stall_needs_word_a, in_stall_o, out_valid_o,
                     "input stalled with no word pending")
  `RLGBM_ASSERT_IMPL(image_end_ends_run_a, out_valid_o && last_of_image_o, last_of_run_o,
                     "image end word not last of its run")
  `RLGBM_ASSERT_NEXT(run_continues_a, out_valid_o && !out_stall_i && !last_of_run_o,
                     out_valid_o, "run dropped before its last word")

endmodule

`default_nettype wire

// File: tb/tb_rgb555_luma_gradient_bump_map.sv
// ----------------------------------------------------------------------------
// tb_rgb555_luma_gradient_bump_map
// Streams RGB555 pixels into the bump mapper under several image sizes and
// random idling on both channels. A scoreboard tracks gray values and raster
// position, queues the expected gradient words and checks every output word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb555_luma_gradient_bump_map;
  timeunit 1ns;
  timeprecision 1ps;

  import rlgbm_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [GrayW-1:0]  du;
    logic [GrayW-1:0]  dv;
    logic              last_run;
    logic              last_image;
  } bump_word_t;

  class bump_tracker;
    bump_word_t     pending[$];
    logic [GrayW-1:0] row_grays [256];
    logic [GrayW-1:0] prev_gray = '0;
    int             cur_row = 0;
    int             cur_col = 0;
    logic [CfgW-1:0] width_reg = CfgReset;
    logic [CfgW-1:0] height_reg = CfgReset;
    int             mismatches = 0;

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > 256) return 256;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > 256) return 256;
      return int'(height_reg);
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      if (idx == CfgImageWidth) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
      cur_row = 0;
      cur_col = 0;
    endfunction

    function void add_pixel(logic [PixW-1:0] pix);
      int red;
      int green;
      int blue;
      int gray;
      int w;
      int h;
      int r;
      int c;
      logic [GrayW-1:0] g8;
      logic [GrayW-1:0] center;
      logic [GrayW-1:0] right;
      bump_word_t word;
      bump_word_t step_words[$];
      red   = int'(pix[14:10]) << 3;
      green = int'(pix[9:5]) << 3;
      blue  = int'(pix[4:0]) << 3;
      gray  = (int'(CoefR) * red + int'(CoefG) * green + int'(CoefB) * blue) / 100;
      g8    = GrayW'(gray);
      w = eff_width();
      h = eff_height();
      r = cur_row;
      c = cur_col;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      // upper row word completes once the pixel below arrives
      if (r >= 1) begin
        center = row_grays[c];
        right  = (c + 1 < w) ? row_grays[c + 1] : center;
        word.row        = CoordW'(r - 1);
        word.col        = CoordW'(c);
        word.du         = center - right;
        word.dv         = center - g8;
        word.last_run   = 1'b0;
        word.last_image = 1'b0;
        step_words.push_back(word);
      end
      if (r == h - 1) begin
        if (c >= 1) begin
          word.row        = CoordW'(r);
          word.col        = CoordW'(c - 1);
          word.du         = prev_gray - g8;
          word.dv         = '0;
          word.last_run   = 1'b0;
          word.last_image = 1'b0;
          step_words.push_back(word);
        end
        if (c == w - 1) begin
          word.row        = CoordW'(r);
          word.col        = CoordW'(c);
          word.du         = '0;
          word.dv         = '0;
          word.last_run   = 1'b0;
          word.last_image = 1'b1;
          step_words.push_back(word);
        end
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last_run = 1'b1;
      foreach (step_words[i]) pending.push_back(step_words[i]);
      row_grays[c] = g8;
      prev_gray = g8;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      cur_row = r;
      cur_col = c;
    endfunction

    function void note(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_word(bump_word_t got);
      bump_word_t want;
      if (pending.size() == 0) begin
        note($sformatf("word with nothing pending: row %0d col %0d du %0d dv %0d",
                       got.row, got.col, $signed(got.du), $signed(got.dv)));
        return;
      end
      want = pending.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.du !== want.du ||
          got.dv !== want.dv || got.last_run !== want.last_run ||
          got.last_image !== want.last_image) begin
        note($sformatf({"mismatch: want row %0d col %0d du %0d dv %0d run %0b img %0b\n",
                        "          got  row %0d col %0d du %0d dv %0d run %0b img %0b"},
                       want.row, want.col, $signed(want.du), $signed(want.dv),
                       want.last_run, want.last_image,
                       got.row, got.col, $signed(got.du), $signed(got.dv),
                       got.last_run, got.last_image));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgImageWidth;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_color_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CoordW-1:0]   out_row_o;
  logic [CoordW-1:0]   out_col_o;
  logic signed [GrayW-1:0] delta_u_o;
  logic signed [GrayW-1:0] delta_v_o;
  logic                last_of_run_o;
  logic                last_of_image_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  logic [PixW-1:0] corner_colors [9] = '{16'h0000, 16'hFFFF, 16'h7C00, 16'h03E0,
                                         16'h001F, 16'h8000, 16'h7FFF, 16'h5555,
                                         16'h2AAA};

  bump_tracker tracker = new();

  rgb555_luma_gradient_bump_map DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_color_i   (pixel_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .delta_u_o       (delta_u_o),
    .delta_v_o       (delta_v_o),
    .last_of_run_o   (last_of_run_o),
    .last_of_image_o (last_of_image_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver side: long holds first, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_word('{out_row_o, out_col_o, delta_u_o, delta_v_o,
                           last_of_run_o, last_of_image_o});
    end
  end

  function automatic logic [PixW-1:0] random_pixel();
    if ($urandom_range(7) == 0) return corner_colors[$urandom_range(8)];
    return PixW'($urandom_range(65535));
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    tracker.add_pixel(pix);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  // a pixel with no word may still sit in the pipeline
  task automatic settle();
    wait_drained();
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgW-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  task automatic set_size(input int w, input int h);
    write_register(CfgImageWidth, CfgW'(w));
    write_register(CfgImageHeight, CfgW'(h));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic random_images(input int budget);
    int sent;
    int pick;
    int area;
    int count;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(2);
      if (pick != 2) begin
        write_register(CfgImageWidth, ($urandom_range(5) == 0) ?
                       CfgW'($urandom_range(11, 40)) : CfgW'($urandom_range(10)));
      end
      if (pick != 1) write_register(CfgImageHeight, CfgW'($urandom_range(6)));
      area = tracker.eff_width() * tracker.eff_height();
      if ($urandom_range(3) != 0 && area <= 60) begin
        count = area * $urandom_range(1, 2);
      end else begin
        count = $urandom_range(1, (area < 30) ? area * 2 : 60);
      end
      send_random(count);
      sent += count;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 68;

    // 3x3 covers zero to three words per pixel, then wrap into the next image
    set_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(corner_colors[i]);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    // zero sizes act as one
    set_size(0, 0);
    for (int i = 0; i < 3; i++) send_pixel(corner_colors[i]);
    // single column
    set_size(1, 3);
    for (int i = 3; i < 6; i++) send_pixel(corner_colors[i]);
    // single row
    set_size(4, 1);
    for (int i = 5; i < 9; i++) send_pixel(corner_colors[i]);

    // long output hold so the pipeline fills and backs up
    set_size(4, 8);
    hold_left = 60;
    send_random(32);
    random_images(25);

    send_idle_pct = 68;
    recv_idle_pct = 31;
    set_size(5, 6);
    send_random(12);
    wait_drained();
    send_random(18);
    random_images(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // saturated sizes
    set_size(511, 1);
    send_random(256);
    set_size(0, 511);
    send_random(40);
    random_images(25);

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: rgb555_luma_gradient_bump_map.f
+incdir+design
design/rlgbm_pkg.sv
design/rlgbm_line_buf.sv
design/rgb555_luma_gradient_bump_map.sv
tb/tb_rgb555_luma_gradient_bump_map.sv
